// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg: shared types and helpers for the complex arithmetic unit
// Fixed point format, operation codes, the divider cell payload and the
// saturating clamp used by the add, subtract, multiply and divide results.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_W  = 32;             // Q16.16 operand width
    localparam int FRAC_W  = 16;             // fraction bits
    localparam int PROD_W  = 2 * DATA_W;     // magnitude product width
    localparam int SUM_W   = PROD_W + 2;     // signed sum of two products
    localparam int QUO_W   = DATA_W;         // quotient bits kept
    localparam int N_CELLS = QUO_W;          // one divider cell per quotient bit

    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    // One division lane (real or imaginary part)
    typedef struct packed {
        logic              neg;   // sign of the quotient
        logic              ovf;   // quotient does not fit QUO_W bits
        logic [PROD_W-1:0] prem;  // partial remainder, below den while ovf is clear
        logic [QUO_W-1:0]  low;   // dividend bits not yet shifted in
        logic [QUO_W-1:0]  quo;   // quotient bits developed so far
    } lane_t;

    // Item as it travels down the divider chain
    typedef struct packed {
        logic              is_div;
        logic              zdiv;
        logic [PROD_W-1:0] den;
        lane_t             re;
        lane_t             im;
        logic [DATA_W-1:0] res_real; // finished result for non-divide modes
        logic [DATA_W-1:0] res_imag;
        logic              sat;
    } cell_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } clamp_t;

    // Signed magnitude to saturated two's complement
    function automatic clamp_t clamp(input logic neg, input logic [PROD_W-1:0] mag);
        clamp_t r;
        r.sat = 1'b0;
        if (neg) begin
            if (mag > {{(PROD_W-DATA_W){1'b0}}, MIN_NEG}) begin
                r.sat = 1'b1;
                r.val = MIN_NEG;
            end
            else begin
                r.val = ~mag[DATA_W-1:0] + 1'b1;
            end
        end
        else begin
            if (mag > {{(PROD_W-DATA_W){1'b0}}, MAX_POS}) begin
                r.sat = 1'b1;
                r.val = MAX_POS;
            end
            else begin
                r.val = mag[DATA_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: Q16.16 complex add, subtract, multiply, divide
// Streaming top level: front pipeline, divider cell chain, output register.
// ----------------------------------------------------------------------------
// Takes one item per cycle while m_axis_tready stays high and returns one
// result item per input item, in order. Every mode passes 4 front stages,
// 32 divider cells and 1 output register, since all items ride the same
// chain. Each stage holds its own valid bit, so gaps close up under
// back-pressure and the input keeps taking items while a result waits at
// the output, until the stages fill. Multiply truncates toward zero after
// dropping 16 fraction bits; divide gives (A * conj(B)) * 2^16 / |B|^2
// truncated toward zero, one quotient bit per divider cell. A divide by
// B = 0 returns the largest positive value in both parts with zero_divisor
// and saturated set. Any part outside the 32-bit range clamps and sets
// saturated. Give a scalar as a complex value with zero imaginary part.
module complex_arithmetic_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_real[31:0], a_imag, b_real, b_imag
    input  logic [1:0]   s_axis_tuser,  // mode[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // res_real[31:0], res_imag[63:32]
    output logic [1:0]   m_axis_tuser   // zero_divisor[0], saturated[1]
);

    localparam int DW = cau_pkg::DATA_W;
    localparam int NC = cau_pkg::N_CELLS;

    // front -> chain[0] -> ... -> chain[NC] -> back
    logic           ch_valid [NC+1];
    logic           ch_ready [NC+1];
    cau_pkg::cell_t ch_data  [NC+1];

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .mode      (cau_pkg::mode_t'(s_axis_tuser)),
        .a_real    (s_axis_tdata[DW-1:0]),
        .a_imag    (s_axis_tdata[2*DW-1:DW]),
        .b_real    (s_axis_tdata[3*DW-1:2*DW]),
        .b_imag    (s_axis_tdata[4*DW-1:3*DW]),
        .out_valid (ch_valid[0]),
        .out_ready (ch_ready[0]),
        .out_data  (ch_data[0])
    );

    // one quotient bit per cell, most significant first
    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        cau_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ch_valid[i]),
            .in_ready  (ch_ready[i]),
            .in_data   (ch_data[i]),
            .out_valid (ch_valid[i+1]),
            .out_ready (ch_ready[i+1]),
            .out_data  (ch_data[i+1])
        );
    end

    cau_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (ch_valid[NC]),
        .in_ready     (ch_ready[NC]),
        .in_data      (ch_data[NC]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .res_real     (m_axis_tdata[DW-1:0]),
        .res_imag     (m_axis_tdata[2*DW-1:DW]),
        .zero_divisor (m_axis_tuser[0]),
        .saturated    (m_axis_tuser[1])
    );

endmodule

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front: operand pipeline ahead of the divider chain
// Input register, magnitude products, signed product sums and the setup of
// the division lanes. Add, subtract and multiply finish here.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cau_pkg::mode_t            mode,
    input  logic [cau_pkg::DATA_W-1:0] a_real,
    input  logic [cau_pkg::DATA_W-1:0] a_imag,
    input  logic [cau_pkg::DATA_W-1:0] b_real,
    input  logic [cau_pkg::DATA_W-1:0] b_imag,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cau_pkg::cell_t            out_data
);

    localparam int DW = cau_pkg::DATA_W;
    localparam int PW = cau_pkg::PROD_W;
    localparam int SW = cau_pkg::SUM_W;
    localparam int FW = cau_pkg::FRAC_W;
    localparam int QW = cau_pkg::QUO_W;

    // ---------------- stage 1: input register ----------------
    logic           v1_reg;
    cau_pkg::mode_t mode1_reg;
    logic [DW-1:0]  ar1_reg, ai1_reg, br1_reg, bi1_reg;

    // ---------------- stage 2: products ----------------
    logic           v2_reg;
    cau_pkg::mode_t mode2_reg;
    logic [PW-1:0]  p_arbr_reg, p_aibi_reg, p_aibr_reg, p_arbi_reg, p_brbr_reg, p_bibi_reg;
    logic           s_arbr_reg, s_aibi_reg, s_aibr_reg, s_arbi_reg;
    cau_pkg::clamp_t as_re_reg, as_im_reg;

    // ---------------- stage 3: product sums ----------------
    logic           v3_reg;
    cau_pkg::mode_t mode3_reg;
    logic [SW-1:0]  sre_reg, sim_reg;
    logic [PW-1:0]  den3_reg;
    cau_pkg::clamp_t as_re3_reg, as_im3_reg;

    // ---------------- stage 4: lane setup ----------------
    logic           v4_reg;
    cau_pkg::cell_t d4_reg;

    logic rdy1, rdy2, rdy3, rdy4;
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 2 combinational
    logic [DW-1:0] m_ar, m_ai, m_br, m_bi;
    logic [DW:0]   sum_re, sum_im;
    logic          addsub_sub;
    logic          n_re, n_im;
    logic [DW:0]   mag_re, mag_im;

    always_comb
    begin
        m_ar = ar1_reg[DW-1] ? (~ar1_reg + 1'b1) : ar1_reg;
        m_ai = ai1_reg[DW-1] ? (~ai1_reg + 1'b1) : ai1_reg;
        m_br = br1_reg[DW-1] ? (~br1_reg + 1'b1) : br1_reg;
        m_bi = bi1_reg[DW-1] ? (~bi1_reg + 1'b1) : bi1_reg;
        addsub_sub = (mode1_reg == cau_pkg::MODE_SUB);
        if (addsub_sub)
        begin
            sum_re = {ar1_reg[DW-1], ar1_reg} - {br1_reg[DW-1], br1_reg};
            sum_im = {ai1_reg[DW-1], ai1_reg} - {bi1_reg[DW-1], bi1_reg};
        end
        else
        begin
            sum_re = {ar1_reg[DW-1], ar1_reg} + {br1_reg[DW-1], br1_reg};
            sum_im = {ai1_reg[DW-1], ai1_reg} + {bi1_reg[DW-1], bi1_reg};
        end
        n_re   = sum_re[DW];
        n_im   = sum_im[DW];
        mag_re = n_re ? (~sum_re + 1'b1) : sum_re;
        mag_im = n_im ? (~sum_im + 1'b1) : sum_im;
    end

    // stage 3 combinational: signed products
    logic [SW-1:0] sp_arbr, sp_aibi, sp_aibr, sp_arbi;

    function automatic logic [SW-1:0] to_signed(input logic neg, input logic [PW-1:0] m);
        logic [SW-1:0] e;
        e = {2'b00, m};
        return neg ? (~e + 1'b1) : e;
    endfunction

    always_comb
    begin
        sp_arbr = to_signed(s_arbr_reg, p_arbr_reg);
        sp_aibi = to_signed(s_aibi_reg, p_aibi_reg);
        sp_aibr = to_signed(s_aibr_reg, p_aibr_reg);
        sp_arbi = to_signed(s_arbi_reg, p_arbi_reg);
    end

    // stage 4 combinational
    logic            nre4, nim4;
    logic [SW-1:0]   are4, aim4;
    logic [PW-1:0]   mre4, mim4;
    cau_pkg::clamp_t cmul_re, cmul_im;
    cau_pkg::cell_t  d4_next;

    always_comb
    begin
        nre4 = sre_reg[SW-1];
        nim4 = sim_reg[SW-1];
        are4 = nre4 ? (~sre_reg + 1'b1) : sre_reg;
        aim4 = nim4 ? (~sim_reg + 1'b1) : sim_reg;
        mre4 = are4[PW-1:0];
        mim4 = aim4[PW-1:0];
        cmul_re = cau_pkg::clamp(nre4, mre4 >> FW);
        cmul_im = cau_pkg::clamp(nim4, mim4 >> FW);

        d4_next.is_div = (mode3_reg == cau_pkg::MODE_DIV);
        d4_next.zdiv   = (mode3_reg == cau_pkg::MODE_DIV) && (den3_reg == '0);
        d4_next.den    = den3_reg;

        // quotient fits QW bits only when mag * 2^FW < den * 2^QW
        d4_next.re.neg  = nre4;
        d4_next.re.ovf  = ({{FW{1'b0}}, mre4} >= {den3_reg, {FW{1'b0}}});
        d4_next.re.prem = {{(QW-FW){1'b0}}, mre4[PW-1:QW-FW]};
        d4_next.re.low  = {mre4[QW-FW-1:0], {FW{1'b0}}};
        d4_next.re.quo  = '0;
        d4_next.im.neg  = nim4;
        d4_next.im.ovf  = ({{FW{1'b0}}, mim4} >= {den3_reg, {FW{1'b0}}});
        d4_next.im.prem = {{(QW-FW){1'b0}}, mim4[PW-1:QW-FW]};
        d4_next.im.low  = {mim4[QW-FW-1:0], {FW{1'b0}}};
        d4_next.im.quo  = '0;

        unique case (mode3_reg) inside
            cau_pkg::MODE_ADD, cau_pkg::MODE_SUB:
            begin
                d4_next.res_real = as_re3_reg.val;
                d4_next.res_imag = as_im3_reg.val;
                d4_next.sat      = as_re3_reg.sat | as_im3_reg.sat;
            end
            cau_pkg::MODE_MUL:
            begin
                d4_next.res_real = cmul_re.val;
                d4_next.res_imag = cmul_im.val;
                d4_next.sat      = cmul_re.sat | cmul_im.sat;
            end
            default:
            begin
                // divide: a zero divisor finishes here
                d4_next.res_real = cau_pkg::MAX_POS;
                d4_next.res_imag = cau_pkg::MAX_POS;
                d4_next.sat      = 1'b1;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            mode1_reg <= mode;
            ar1_reg   <= a_real;
            ai1_reg   <= a_imag;
            br1_reg   <= b_real;
            bi1_reg   <= b_imag;
        end
        if (rdy2 && v1_reg)
        begin
            mode2_reg  <= mode1_reg;
            p_arbr_reg <= PW'(m_ar) * PW'(m_br);
            p_aibi_reg <= PW'(m_ai) * PW'(m_bi);
            p_aibr_reg <= PW'(m_ai) * PW'(m_br);
            p_arbi_reg <= PW'(m_ar) * PW'(m_bi);
            p_brbr_reg <= PW'(m_br) * PW'(m_br);
            p_bibi_reg <= PW'(m_bi) * PW'(m_bi);
            s_arbr_reg <= ar1_reg[DW-1] ^ br1_reg[DW-1];
            s_aibi_reg <= ai1_reg[DW-1] ^ bi1_reg[DW-1];
            s_aibr_reg <= ai1_reg[DW-1] ^ br1_reg[DW-1];
            s_arbi_reg <= ar1_reg[DW-1] ^ bi1_reg[DW-1];
            as_re_reg  <= cau_pkg::clamp(n_re, {{(PW-DW-1){1'b0}}, mag_re});
            as_im_reg  <= cau_pkg::clamp(n_im, {{(PW-DW-1){1'b0}}, mag_im});
        end
        if (rdy3 && v2_reg)
        begin
            mode3_reg  <= mode2_reg;
            den3_reg   <= p_brbr_reg + p_bibi_reg;
            as_re3_reg <= as_re_reg;
            as_im3_reg <= as_im_reg;
            if (mode2_reg == cau_pkg::MODE_DIV)
            begin
                sre_reg <= sp_arbr + sp_aibi;
                sim_reg <= sp_aibr - sp_arbi;
            end
            else
            begin
                sre_reg <= sp_arbr - sp_aibi;
                sim_reg <= sp_aibr + sp_arbi;
            end
        end
        if (rdy4 && v3_reg)
        begin
            d4_reg <= d4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = d4_reg;

endmodule

// ===== rtl/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// cau_div_cell: one restoring division step for both lanes
// Shifts one dividend bit into each partial remainder, subtracts the
// divisor where it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module cau_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cau_pkg::cell_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cau_pkg::cell_t out_data
);

    localparam int PW = cau_pkg::PROD_W;
    localparam int QW = cau_pkg::QUO_W;

    logic           v_reg;
    cau_pkg::cell_t d_reg;
    cau_pkg::cell_t d_next;

    function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l, input logic [PW-1:0] den);
        cau_pkg::lane_t r;
        logic [PW:0]    t;
        r = l;
        t = {l.prem, l.low[QW-1]};
        if (t >= {1'b0, den})
        begin
            t      = t - {1'b0, den};
            r.quo  = {l.quo[QW-2:0], 1'b1};
        end
        else
        begin
            r.quo  = {l.quo[QW-2:0], 1'b0};
        end
        r.prem = t[PW-1:0];
        r.low  = {l.low[QW-2:0], 1'b0};
        return r;
    endfunction

    always_comb
    begin
        d_next    = in_data;
        d_next.re = step(in_data.re, in_data.den);
        d_next.im = step(in_data.im, in_data.den);
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

// ===== rtl/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back: result selection and output register
// Turns division quotients into saturated results and holds the item
// until the sink takes it.
// ----------------------------------------------------------------------------
module cau_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cau_pkg::cell_t             in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cau_pkg::DATA_W-1:0] res_real,
    output logic [cau_pkg::DATA_W-1:0] res_imag,
    output logic                       zero_divisor,
    output logic                       saturated
);

    localparam int DW = cau_pkg::DATA_W;
    localparam int PW = cau_pkg::PROD_W;
    localparam int QW = cau_pkg::QUO_W;

    logic          v_reg;
    logic [DW-1:0] re_reg, im_reg;
    logic          zd_reg, sat_reg;

    function automatic cau_pkg::clamp_t finish(input cau_pkg::lane_t l);
        cau_pkg::clamp_t r;
        if (l.ovf)
        begin
            r.sat = 1'b1;
            r.val = l.neg ? cau_pkg::MIN_NEG : cau_pkg::MAX_POS;
        end
        else
        begin
            r = cau_pkg::clamp(l.neg, {{(PW-QW){1'b0}}, l.quo});
        end
        return r;
    endfunction

    cau_pkg::clamp_t q_re, q_im;
    logic [DW-1:0]   re_next, im_next;
    logic            sat_next;

    always_comb
    begin
        q_re = finish(in_data.re);
        q_im = finish(in_data.im);
        if (in_data.is_div && !in_data.zdiv)
        begin
            re_next  = q_re.val;
            im_next  = q_im.val;
            sat_next = q_re.sat | q_im.sat;
        end
        else
        begin
            re_next  = in_data.res_real;
            im_next  = in_data.res_imag;
            sat_next = in_data.sat;
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            zd_reg  <= in_data.zdiv;
            sat_reg <= sat_next;
        end
    end

    assign out_valid    = v_reg;
    assign res_real     = re_reg;
    assign res_imag     = im_reg;
    assign zero_divisor = zd_reg;
    assign saturated    = sat_reg;

endmodule

// ===== rtl/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker: port-level checks for the complex arithmetic unit
// Watches the result stream; bound to the top level below.
// ----------------------------------------------------------------------------
module cau_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a stalled result item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a zero divisor always counts as saturation
    a_zd_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("zero divisor without saturated flag");

    // a zero divisor gives the largest positive value in both parts
    a_zd_val: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[31:0] == cau_pkg::MAX_POS && m_axis_tdata[63:32] == cau_pkg::MAX_POS)
        else $error("zero divisor result not at positive limit");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit: self-checking bench for the complex ALU
// Sends directed corner cases and then random Q16.16 operand pairs in all
// four modes. Each result is checked against an in-bench fixed-point
// predictor. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;

    localparam logic [31:0] TOP = cau_pkg::MAX_POS;
    localparam logic [31:0] BOT = cau_pkg::MIN_NEG;
    localparam int          FW  = cau_pkg::FRAC_W;

    typedef struct packed {
        cau_pkg::mode_t mode;
        logic [31:0]    ar;
        logic [31:0]    ai;
        logic [31:0]    br;
        logic [31:0]    bi;
    } op_item_t;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        zd;
        logic        sat;
    } cplx_res_t;

    localparam int IDLE_PCT    = 38;
    localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int N_RANDOM    = 1800;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    op_item_t  pending_ops[$];
    cplx_res_t expected_results[$];
    int        n_errors;
    int        n_checked;
    int        n_sat_seen;
    int        n_zdiv_seen;
    int        mode_count[4];
    int        quiet_cycles;
    int        cycle_cnt;
    logic      no_idle;          // long stretch without idling on either side

    complex_arithmetic_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // a_real, a_imag, b_real, b_imag from bit 0
        .s_axis_tuser  (s_axis_tuser),  // mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),  // res_real, res_imag from bit 0
        .m_axis_tuser  (m_axis_tuser)   // zero_divisor, saturated from bit 0
    );

    always #5 clk = ~clk;

    // Clamp a wide signed value to 32 bits, flagging any clamping
    function automatic logic [31:0] clamp_part(input logic signed [127:0] v,
                                               inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return TOP;
        end
        else if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return BOT;
        end
        return v[31:0];
    endfunction

    // Signed value scaled down by 2^16, truncated toward zero
    function automatic logic signed [127:0] drop_frac(input logic signed [127:0] v);
        if (v < 0)
            return -((-v) >>> FW);
        return v >>> FW;
    endfunction

    function automatic cplx_res_t complex_result(input op_item_t it);
        logic signed [127:0] xr, xi, yr, yi, re, im, den, mag;
        cplx_res_t r;
        xr = $signed(it.ar);
        xi = $signed(it.ai);
        yr = $signed(it.br);
        yi = $signed(it.bi);
        r.zd  = 1'b0;
        r.sat = 1'b0;
        case (it.mode)
            cau_pkg::MODE_ADD: begin
                re = xr + yr;
                im = xi + yi;
            end
            cau_pkg::MODE_SUB: begin
                re = xr - yr;
                im = xi - yi;
            end
            cau_pkg::MODE_MUL: begin
                re = drop_frac(xr * yr - xi * yi);
                im = drop_frac(xi * yr + xr * yi);
            end
            default: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.re  = TOP;
                    r.im  = TOP;
                    r.zd  = 1'b1;
                    r.sat = 1'b1;
                    return r;
                end
                // A * conj(B) scaled by 2^16 over |B|^2, truncated toward zero
                re  = xr * yr + xi * yi;
                mag = (re < 0) ? -re : re;
                mag = (mag <<< FW) / den;
                re  = (re < 0) ? -mag : mag;
                im  = xi * yr - xr * yi;
                mag = (im < 0) ? -im : im;
                mag = (mag <<< FW) / den;
                im  = (im < 0) ? -mag : mag;
            end
        endcase
        r.re = clamp_part(re, r.sat);
        r.im = clamp_part(im, r.sat);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("ERROR at cycle %0d: %s got %h expected %h", cycle_cnt, what, got, want);
    endtask

    // Operand mix: full range, small values near 1.0, zeros and extremes
    function automatic logic [31:0] rand_part();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: return $urandom;
            3, 4, 5: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
            6:       return 32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
            7:       return '0;
            8:       return ($urandom_range(0, 1) != 0) ? TOP : BOT;
            default: return 32'($signed($urandom_range(0, 2 ** 17)) - 2 ** 16);
        endcase
    endfunction

    task automatic add_op(input cau_pkg::mode_t m, input logic [31:0] ar,
                          input logic [31:0] ai, input logic [31:0] br,
                          input logic [31:0] bi);
        op_item_t it;
        it.mode = m;
        it.ar = ar;
        it.ai = ai;
        it.br = br;
        it.bi = bi;
        pending_ops.push_back(it);
    endtask

    // Driver: holds the item until accepted, then loads the next or idles
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                op_item_t done;
                done.mode = cau_pkg::mode_t'(s_axis_tuser);
                {done.bi, done.br, done.ai, done.ar} = s_axis_tdata;
                expected_results.push_back(complex_result(done));
                mode_count[done.mode]++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ops.size() > 0 &&
                    (no_idle || $urandom_range(1, 100) > IDLE_PCT)) begin
                    op_item_t it;
                    it = pending_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {it.bi, it.br, it.ai, it.ar};
                    s_axis_tuser  <= it.mode;
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and field-by-field compare
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= no_idle || ($urandom_range(1, 100) > IDLE_PCT);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
                end
                else begin
                    cplx_res_t want;
                    want = expected_results.pop_front();
                    n_checked++;
                    if (m_axis_tdata[31:0] !== want.re)
                        report_mismatch("res_real", m_axis_tdata[31:0], want.re);
                    if (m_axis_tdata[63:32] !== want.im)
                        report_mismatch("res_imag", m_axis_tdata[63:32], want.im);
                    if (m_axis_tuser[0] !== want.zd)
                        report_mismatch("zero_divisor", 32'(m_axis_tuser[0]), 32'(want.zd));
                    if (m_axis_tuser[1] !== want.sat)
                        report_mismatch("saturated", 32'(m_axis_tuser[1]), 32'(want.sat));
                    n_sat_seen  += want.sat;
                    n_zdiv_seen += want.zd;
                end
            end
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge clk) begin
        if (rst_n) begin
            cycle_cnt <= cycle_cnt + 1;
            no_idle   <= (cycle_cnt > 1500 && cycle_cnt < 2300);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no item moved in %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        n_errors     = 0;
        n_checked    = 0;
        n_sat_seen   = 0;
        n_zdiv_seen  = 0;
        quiet_cycles = 0;
        cycle_cnt    = 0;
        no_idle      = 1'b0;
        foreach (mode_count[i]) mode_count[i] = 0;

        // Directed: extremes in every mode, zero divisor, unit and scalar cases
        add_op(cau_pkg::MODE_ADD, TOP, BOT, TOP, BOT);
        add_op(cau_pkg::MODE_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_0001);
        add_op(cau_pkg::MODE_SUB, BOT, TOP, TOP, BOT);
        add_op(cau_pkg::MODE_SUB, 32'h0000_0000, 32'h0000_0000, BOT, 32'h0000_0001);
        add_op(cau_pkg::MODE_MUL, BOT, BOT, BOT, BOT);
        add_op(cau_pkg::MODE_MUL, TOP, TOP, TOP, BOT);
        add_op(cau_pkg::MODE_MUL, 32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000);
        add_op(cau_pkg::MODE_MUL, 32'h0003_8000, 32'hFFFE_4000, 32'h0000_0001, 32'hFFFF_FFFF);
        add_op(cau_pkg::MODE_MUL, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        add_op(cau_pkg::MODE_DIV, 32'h0005_0000, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000);
        add_op(cau_pkg::MODE_DIV, BOT, TOP, 32'h0000_0000, 32'h0000_0000);
        add_op(cau_pkg::MODE_DIV, 32'h0007_0000, 32'hFFFD_0000, 32'h0001_0000, 32'h0000_0000);
        add_op(cau_pkg::MODE_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0003, 32'h0000_0000);
        add_op(cau_pkg::MODE_DIV, TOP, BOT, 32'h0000_0001, 32'h0000_0001);
        add_op(cau_pkg::MODE_DIV, BOT, BOT, BOT, BOT);
        add_op(cau_pkg::MODE_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000);
        add_op(cau_pkg::MODE_DIV, 32'hFFFF_FFFF, 32'h0000_0001, TOP, TOP);
        add_op(cau_pkg::MODE_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, BOT);

        for (int i = 0; i < N_RANDOM; i++) begin
            cau_pkg::mode_t m;
            logic [31:0] br, bi;
            m  = cau_pkg::mode_t'($urandom_range(0, 3));
            br = rand_part();
            bi = rand_part();
            // keep zero divisors rare so most divides do real work
            if (m == cau_pkg::MODE_DIV && br == 0 && bi == 0 && $urandom_range(0, 3) != 0)
                br = 32'h0001_0000;
            add_op(m, rand_part(), rand_part(), br, bi);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
        repeat (60) @(posedge clk);

        $display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d",
                 n_checked, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
        $display("Saturated results %0d, zero-divisor results %0d",
                 n_sat_seen, n_zdiv_seen);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_cell.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
verif/tb_complex_arithmetic_unit.sv
